// File: rtl/utf8ld_pkg.sv
// Constants shared by the lenient UTF-8 decoder.
// Has no dependencies; the top level imports it.
`default_nettype none

package utf8ld_pkg;

    localparam int unsigned CP_W    = 31;
    localparam int unsigned COUNT_W = 3;

    typedef logic [CP_W-1:0]    code_point_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam logic [7:0]  CONT_TAG_MASK = 8'hC0;
    localparam logic [7:0]  CONT_TAG      = 8'h80;
    localparam code_point_t BOM_CODE      = 31'h0000FEFF;
    localparam count_t      MAX_REMAINING = 3'd5;

endpackage

`default_nettype wire

// File: rtl/utf8_lenient_decoder.sv
// Lenient UTF-8 byte stream decoder with a registered result stage.
// Depends on utf8ld_pkg for widths and byte class constants.
//
// Channel | Beat fields            | Handshake
// --------+------------------------+----------------------
// input   | in_byte, end_of_input  | in_valid / in_ready
// output  | code_point, is_end     | out_valid / out_ready
//
// One beat per cycle when in_ready is high; results show the cycle after.
// The sequence count and accumulator update in the cycle the beat is taken.
// Reset clears the sequence state and the result valid flag.
// in_ready drops only while a result is held and out_ready is low.
`default_nettype none

module utf8_lenient_decoder
    import utf8ld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [30:0]      code_point,
    output logic             is_end
);

    count_t      remaining_reg;
    count_t      remaining_next;
    code_point_t acc_reg;
    code_point_t acc_next;
    logic        out_valid_reg;
    code_point_t code_point_reg;
    logic        is_end_reg;

    logic        in_accept;
    logic        emit;
    code_point_t emit_cp;
    logic        emit_end;
    code_point_t shifted;
    count_t      remaining_dec;
    logic        is_cont;

    assign in_ready      = !out_valid_reg || out_ready;
    assign in_accept     = in_valid && in_ready;
    assign shifted       = {acc_reg[CP_W-7:0], in_byte[5:0]};
    assign remaining_dec = remaining_reg - count_t'(1);
    assign is_cont       = (in_byte & CONT_TAG_MASK) == CONT_TAG;

    always_comb
    begin
        logic lead_path;
        lead_path      = 1'b0;
        remaining_next = remaining_reg;
        acc_next       = acc_reg;
        emit           = 1'b0;
        emit_cp        = '0;
        emit_end       = 1'b0;
        if (end_of_input)
        begin
            remaining_next = '0;
            acc_next       = '0;
            emit           = 1'b1;
            emit_end       = 1'b1;
        end
        else if (remaining_reg != '0 && is_cont)
        begin
            remaining_next = remaining_dec;
            acc_next       = shifted;
            if (remaining_dec == '0)
            begin
                acc_next = '0;
                if (shifted != BOM_CODE)
                begin
                    emit    = 1'b1;
                    emit_cp = shifted;
                end
            end
        end
        else
        begin
            remaining_next = '0;
            acc_next       = '0;
            lead_path      = 1'b1;
        end

        if (lead_path)
        begin
            unique case (in_byte) inside
                [8'h00:8'h7F]:
                begin
                    emit    = 1'b1;
                    emit_cp = code_point_t'(in_byte);
                end
                [8'hC0:8'hDF]:
                begin
                    remaining_next = 3'd1;
                    acc_next       = code_point_t'(in_byte[4:0]);
                end
                [8'hE0:8'hEF]:
                begin
                    remaining_next = 3'd2;
                    acc_next       = code_point_t'(in_byte[3:0]);
                end
                [8'hF0:8'hF7]:
                begin
                    remaining_next = 3'd3;
                    acc_next       = code_point_t'(in_byte[2:0]);
                end
                [8'hF8:8'hFB]:
                begin
                    remaining_next = 3'd4;
                    acc_next       = code_point_t'(in_byte[1:0]);
                end
                [8'hFC:8'hFD]:
                begin
                    remaining_next = MAX_REMAINING;
                    acc_next       = code_point_t'(in_byte[0]);
                end
                default:
                begin
                    remaining_next = '0;
                    acc_next       = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                remaining_reg <= remaining_next;
                acc_reg       <= acc_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            code_point_reg <= emit_cp;
            is_end_reg     <= emit_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign is_end     = is_end_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= MAX_REMAINING)
        else $error("Continuation count is out of range.");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_input |=> out_valid_reg && is_end_reg)
        else $error("End of input did not produce an end result.");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_input |=> remaining_reg == '0 && acc_reg == '0)
        else $error("End of input left a partial sequence.");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_end_reg |-> code_point_reg == '0)
        else $error("End result carries a nonzero code point.");

    a_idle_acc: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg == '0 |-> acc_reg == '0)
        else $error("Accumulator is not clear between sequences.");

endmodule

`default_nettype wire
